[src/asfc_pkg.sv]
package asfc_pkg;

    localparam int MaxWindow = 16;
    localparam int PosW      = $clog2(MaxWindow);
    localparam int SampW     = 12;
    localparam int SumW      = 16;
    localparam int StateW    = 28;
    localparam int VarW      = 24;
    localparam int GainW     = 17;
    localparam int WinW      = 5;

    localparam logic [GainW-1:0] OneQ16 = 17'h10000;
    localparam logic [VarW-1:0]  VarMax = 24'hFFFFFF;

    localparam logic [1:0] RegWindow = 2'd0;
    localparam logic [1:0] RegGain   = 2'd1;
    localparam logic [1:0] RegQ      = 2'd2;
    localparam logic [1:0] RegR      = 2'd3;

    typedef enum logic [3:0] {
        t_idle_st, t_rd_st, t_sum_st, t_div_avg_st, t_ema_mul_st, t_ema_add_st,
        t_kal_pre_st, t_div_k_st, t_kal_mul_st, t_kal_add_st, t_out_st, t_clr_st
    } t_state;

endpackage

[src/adc_sample_filter_chain.sv]
// Channel | Direction | Handshake           | Payload
// in      | input     | i_valid / o_ready   | i_sample
// out     | output    | o_valid / i_ready   | o_average_value, o_smoothed_value,
//         |           |                     | o_filtered_value
// cfg     | input     | i_cfg_we            | i_cfg_index, i_cfg_data
// o_valid rises once a taken word has gone through: read, sum, a 16-step restoring divide
// for the average, two EMA steps, a setup step, a 17-step divide for the Kalman gain,
// then multiply-add and output steps.
// The ring store is a 16-entry memory read in the cycle before the write-back.
// After reset, and after a window length write, a sweep in t_clr_st clears the store.
// A result waits in the output register; the next word is taken once it leaves.
module adc_sample_filter_chain
    import asfc_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  logic [11:0]      i_sample,
    output logic             o_valid,
    input  logic             i_ready,
    output logic [11:0]      o_average_value,
    output logic [11:0]      o_smoothed_value,
    output logic [11:0]      o_filtered_value,
    input  logic             i_cfg_we,
    input  logic [1:0]       i_cfg_index,
    input  logic [23:0]      i_cfg_data
);

    logic [SampW-1:0] mem [MaxWindow];
    logic [SampW-1:0] r_rd_data;

    t_state r_state, n_state;
    logic [WinW-1:0]  r_win;
    logic [GainW-1:0] r_gain;
    logic [VarW-1:0]  r_q, r_r;
    logic [PosW-1:0]  r_pos;
    logic [SumW-1:0]  r_sum;
    logic [StateW-1:0] r_ema, r_est;
    logic [VarW-1:0]  r_p, r_ppred;
    logic [SampW-1:0] r_samp;
    logic [4:0]       r_cnt;
    logic [PosW:0]    r_clr;
    // shared divider: remainder, quotient
    logic [VarW+1:0]  r_rem;
    logic [GainW-1:0] r_quo;
    logic [VarW:0]    r_den;
    logic [SumW+GainW-1:0] r_num;
    logic [GainW-1:0] r_k;
    logic [SampW-1:0] r_avg, r_smooth;
    logic [44:0]      r_pa, r_pb;
    logic             r_ovalid;
    logic [11:0]      r_o_avg, r_o_sm, r_o_flt;

    logic             cfg_win;
    logic [WinW-1:0]  win_clamp;
    logic [GainW-1:0] gain_clamp;
    logic [VarW:0]    p_sum;
    logic [VarW+1:0]  rem_sh;
    logic [GainW-1:0] one_m_k;
    logic [SumW:0]    sum_new;
    logic             div_done;

    assign cfg_win = i_cfg_we && (i_cfg_index == RegWindow);
    assign win_clamp = (i_cfg_data[4:0] == '0) ? WinW'(1)
                     : (i_cfg_data[4:0] > WinW'(MaxWindow)) ? WinW'(MaxWindow)
                     : i_cfg_data[4:0];
    assign gain_clamp = (i_cfg_data[16:0] > OneQ16) ? OneQ16 : i_cfg_data[16:0];
    assign p_sum = {1'b0, r_p} + {1'b0, r_q};
    assign rem_sh = {r_rem[VarW:0], r_num[SumW+GainW-1]};
    assign one_m_k = OneQ16 - r_k;
    assign sum_new = {1'b0, r_sum} - SumW'(r_rd_data) + SumW'(r_samp);
    assign div_done = (r_cnt == '0);
    assign o_ready = (r_state == t_idle_st) && !r_ovalid;
    assign o_valid = r_ovalid;
    assign o_average_value  = r_o_avg;
    assign o_smoothed_value = r_o_sm;
    assign o_filtered_value = r_o_flt;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            t_idle_st:    if (i_valid && o_ready) n_state = t_rd_st;
            t_rd_st:      n_state = t_sum_st;
            t_sum_st:     n_state = t_div_avg_st;
            t_div_avg_st: if (div_done) n_state = t_ema_mul_st;
            t_ema_mul_st: n_state = t_ema_add_st;
            t_ema_add_st: n_state = t_kal_pre_st;
            t_kal_pre_st: n_state = t_div_k_st;
            t_div_k_st:   if (div_done) n_state = t_kal_mul_st;
            t_kal_mul_st: n_state = t_kal_add_st;
            t_kal_add_st: n_state = t_out_st;
            t_out_st:     n_state = t_idle_st;
            t_clr_st:     if (r_clr[PosW]) n_state = t_idle_st;
            default:      n_state = t_idle_st;
        endcase
        if (cfg_win) n_state = t_clr_st;
    end

    // store: read during t_rd_st, write back in t_sum_st, swept in t_clr_st
    always_ff @(posedge i_clk) begin
        r_rd_data <= mem[r_pos];
        if (r_state == t_sum_st) mem[r_pos] <= r_samp;
        else if (r_state == t_clr_st && !r_clr[PosW]) mem[r_clr[PosW-1:0]] <= '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= t_clr_st;
            r_clr <= '0;
            r_win <= WinW'(10);
            r_gain <= GainW'(16384);
            r_q <= VarW'(655);
            r_r <= VarW'(65536);
            r_pos <= '0;
            r_sum <= '0;
            r_ema <= '0;
            r_est <= '0;
            r_p <= '0;
            r_ovalid <= 1'b0;
            r_cnt <= '0;
        end else begin
            r_state <= n_state;
            if (r_ovalid && i_ready) r_ovalid <= 1'b0;
            unique case (r_state)
                t_idle_st: r_samp <= i_sample;
                t_rd_st: ;
                t_sum_st: begin
                    r_sum <= sum_new[SumW-1:0];
                    r_pos <= ({1'b0, r_pos} + 1'b1 >= r_win) ? '0 : r_pos + 1'b1;
                    r_num <= {sum_new[SumW-1:0], {GainW{1'b0}}};
                    r_den <= (VarW+1)'(r_win);
                    r_rem <= '0;
                    r_cnt <= 5'(SumW - 1);
                end
                t_div_avg_st, t_div_k_st: begin
                    r_num <= r_num << 1;
                    if (rem_sh >= {1'b0, r_den}) begin
                        r_rem <= rem_sh - {1'b0, r_den};
                        r_quo <= {r_quo[GainW-2:0], 1'b1};
                    end else begin
                        r_rem <= rem_sh;
                        r_quo <= {r_quo[GainW-2:0], 1'b0};
                    end
                    if (!div_done) r_cnt <= r_cnt - 1'b1;
                end
                t_ema_mul_st: begin
                    r_avg <= r_quo[SampW-1:0];
                    r_pa <= 45'(r_gain) * 45'(r_quo[SampW-1:0]);
                    r_pb <= 45'(OneQ16 - r_gain) * 45'(r_ema);
                end
                t_ema_add_st: begin
                    r_ema <= StateW'(((r_pa << 16) + r_pb) >> 16);
                    r_smooth <= 12'(((r_pa << 16) + r_pb) >> 32);
                    r_ppred <= p_sum[VarW] ? VarMax : p_sum[VarW-1:0];
                end
                t_kal_pre_st: begin
                    // preload the upper dividend bits; they stay below the divisor
                    r_den <= {1'b0, r_ppred} + {1'b0, r_r};
                    r_num <= {r_ppred[0], {(SumW+GainW-1){1'b0}}};
                    r_rem <= {3'b000, r_ppred[VarW-1:1]};
                    r_quo <= '0;
                    r_cnt <= 5'(GainW - 1);
                end
                t_kal_mul_st: begin
                    r_k <= (r_den == '0) ? '0 : r_quo;
                    r_pa <= '0;
                    r_pb <= '0;
                end
                t_kal_add_st: begin
                    r_pa <= 45'(one_m_k) * 45'(r_est) + 45'(r_k) * {17'h0, r_smooth, 16'h0};
                    r_pb <= 45'(one_m_k) * 45'(r_ppred);
                end
                t_out_st: begin
                    r_est <= StateW'(r_pa >> 16);
                    r_p <= VarW'(r_pb >> 16);
                    r_o_avg <= r_avg;
                    r_o_sm <= r_smooth;
                    r_o_flt <= 12'(r_pa >> 32);
                    r_ovalid <= 1'b1;
                end
                t_clr_st: if (!r_clr[PosW]) r_clr <= r_clr + 1'b1;
                default: ;
            endcase
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    RegWindow: begin
                        r_win <= win_clamp;
                        r_clr <= '0;
                        r_pos <= '0;
                        r_sum <= '0;
                        r_ema <= '0;
                        r_est <= '0;
                        r_p <= '0;
                    end
                    RegGain: r_gain <= gain_clamp;
                    RegQ:    r_q <= i_cfg_data;
                    RegR:    r_r <= i_cfg_data;
                    default: ;
                endcase
            end
        end
    end

    a_pos_in_window: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ({1'b0, r_pos} < r_win)) else $error("write position beyond window");
    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != t_idle_st) |-> !o_ready) else $error("ready while busy");
    a_out_after_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_ovalid) |-> $past(r_state == t_out_st)) else $error("stray result");

endmodule
